// ===== rtl/rc_pkg.sv =====
// Shared types, constants and helper functions for the radix converter.
package rc_pkg;

	// Default accumulator width
	localparam int ACC_WIDTH_DEF = 32;

	// Digit buffer geometry
	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = BUF_AW + 1;

	// Dividend bits retired per divider cycle
	localparam int DIV_STEP = 8;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Base registers
	localparam int                BASE_W       = 5;
	localparam logic [BASE_W-1:0] BASE_MIN     = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX     = 5'd16;
	localparam logic [BASE_W-1:0] SRC_BASE_RST = 5'd10;
	localparam logic [BASE_W-1:0] TGT_BASE_RST = 5'd16;

	// APB data width
	localparam int APB_DW = 32;

	// ASCII codes
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_ERR = 8'h00;
	localparam logic [3:0] TEN   = 4'd10;

	// Register indexes
	typedef enum logic {
		REG_SRC_BASE = 1'b0,
		REG_TGT_BASE = 1'b1
	} reg_idx_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_RD,
		BK_OUT
	} back_state_t;

	// Decoded character
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} char_val_t;

	// Out-of-range bases saturate to 2..16
	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN)
			r = BASE_MIN;
		else if (b > BASE_MAX)
			r = BASE_MAX;
		return r;
	endfunction

	// Hex digit decode, upper or lower case
	function automatic char_val_t char_value(input logic [7:0] c);
		char_val_t r;
		logic [7:0] d;
		r.ok  = 1'b1;
		r.val = 4'd0;
		d     = 8'd0;
		if (c >= CH_0 && c <= CH_9) begin
			d     = c - CH_0;
			r.val = d[3:0];
		end else if (c >= CH_UA && c <= CH_UF) begin
			d     = c - CH_UA;
			r.val = d[3:0] + TEN;
		end else if (c >= CH_LA && c <= CH_LF) begin
			d     = c - CH_LA;
			r.val = d[3:0] + TEN;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// Digit value to uppercase ASCII
	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		logic [3:0] hi;
		logic [7:0] r;
		hi = d - TEN;
		if (d < TEN)
			r = CH_0 + {4'd0, d};
		else
			r = CH_UA + {4'd0, hi};
		return r;
	endfunction

endpackage

// ===== rtl/rc_queue.sv =====
// Small job queue that decouples the character front end from the digit back end.
module rc_queue import rc_pkg::*; #(
	parameter int DATA_W = ACC_WIDTH_DEF + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              full,
	output logic              empty
);

	localparam int QA = $clog2(QUEUE_DEPTH);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QA-1:0]     wr_ptr_q;
	logic [QA-1:0]     rd_ptr_q;
	logic [QA:0]       count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == (QA+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QA'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QA'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QA+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QA+1)'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/rc_front.sv =====
// Front end: accumulates decoded chars; one beat per cycle unless q_full.
module rc_front import rc_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	input  logic [BASE_W-1:0]   src_base,
	input  logic                q_full,
	output logic                push,
	output logic [ACC_WIDTH:0]  push_data
);

	localparam int PROD_W = ACC_WIDTH + BASE_W;

	logic [ACC_WIDTH-1:0] acc_q;
	logic                 err_q;
	logic                 accept;
	char_val_t            cv;
	logic [PROD_W-1:0]    prod;
	logic [ACC_WIDTH-1:0] acc_nx;
	logic                 err_nx;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// value = value * base + digit, wrapping at ACC_WIDTH
	always_comb begin
		cv     = char_value(char_code);
		prod   = {{BASE_W{1'b0}}, acc_q} * {{ACC_WIDTH{1'b0}}, src_base};
		acc_nx = cv.ok ? (prod[ACC_WIDTH-1:0] + ACC_WIDTH'(cv.val)) : acc_q;
		err_nx = err_q || !cv.ok;
	end

	assign push      = accept && last_char;
	assign push_data = {err_nx, acc_nx};

	// Accumulator; cleared after the last character of a number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				acc_q <= '0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_nx;
				err_q <= err_nx;
			end
		end
	end

endmodule

// ===== rtl/rc_back.sv =====
// Back end: repeated division by the target base, digit buffer, MSB-first emit.
module rc_back import rc_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [BASE_W-1:0]  tgt_base,
	input  logic               q_empty,
	input  logic [ACC_WIDTH:0] q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         digit_code,
	output logic               last_digit,
	output logic               bad_char
);

	localparam int PAD_W  = ((ACC_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
	localparam int STEPS  = PAD_W / DIV_STEP;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	back_state_t        state_q, state_d;
	logic [PAD_W-1:0]   quo_q, quo_nx;
	logic [3:0]         rem_q, rem_nx;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_m1;
	logic [BUF_AW-1:0]  rd_addr;
	logic [3:0]         buf_q [BUF_DEPTH];
	logic [3:0]         rd_q;
	logic               step_last;
	logic               buf_we;
	logic               start;
	logic               load_out;
	logic [7:0]         code_d;
	logic               last_d;
	logic               bad_d;
	logic               out_valid_q;
	logic [7:0]         code_q;
	logic               last_q;
	logic               bad_q;
	logic               out_free;
	logic [4:0]         r5;

	assign out_free  = !out_valid_q || out_ready;
	assign step_last = (step_q == STEP_W'(STEPS - 1));
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign rd_addr   = cnt_m1[BUF_AW-1:0];

	// One divider cycle: DIV_STEP restoring steps on a narrow remainder
	always_comb begin
		quo_nx = quo_q;
		rem_nx = rem_q;
		r5     = 5'd0;
		for (int k = 0; k < DIV_STEP; k++) begin
			r5     = {rem_nx, quo_nx[PAD_W-1]};
			quo_nx = {quo_nx[PAD_W-2:0], 1'b0};
			if (r5 >= tgt_base) begin
				r5        = r5 - tgt_base;
				quo_nx[0] = 1'b1;
			end
			rem_nx = r5[3:0];
		end
	end

	// Sequencer next state and outputs
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		start    = 1'b0;
		buf_we   = 1'b0;
		load_out = 1'b0;
		code_d   = digit_ascii(rd_q);
		last_d   = (cnt_q == CNT_W'(1));
		bad_d    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_data[ACC_WIDTH]) begin
						if (out_free) begin
							q_pop    = 1'b1;
							load_out = 1'b1;
							code_d   = CH_ERR;
							last_d   = 1'b1;
							bad_d    = 1'b1;
						end
					end else begin
						q_pop   = 1'b1;
						start   = 1'b1;
						state_d = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (step_last) begin
					buf_we = 1'b1;
					if (quo_nx == '0 || cnt_q == CNT_W'(BUF_DEPTH - 1))
						state_d = BK_RD;
				end
			end
			BK_RD: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (cnt_q == CNT_W'(1))
						state_d = BK_IDLE;
					else
						state_d = BK_RD;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start)
				cnt_q <= '0;
			else if (buf_we)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (load_out && state_q == BK_OUT)
				cnt_q <= cnt_m1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= PAD_W'(q_data[ACC_WIDTH-1:0]);
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			quo_q <= quo_nx;
			if (step_last) begin
				rem_q  <= '0;
				step_q <= '0;
			end else begin
				rem_q  <= rem_nx;
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Digit buffer, registered read
	always_ff @(posedge clk) begin
		if (buf_we)
			buf_q[cnt_q[BUF_AW-1:0]] <= rem_nx;
		if (state_q == BK_RD)
			rd_q <= buf_q[rd_addr];
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			code_q <= code_d;
			last_q <= last_d;
			bad_q  <= bad_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_code = code_q;
	assign last_digit = last_q;
	assign bad_char   = bad_q;

endmodule

// ===== rtl/radix_converter.sv =====
// A character is taken each cycle while the job queue is not full. A finished number
// waits in the 2-entry job queue, so new characters can accumulate meanwhile, until the
// back end, which takes one number at a time, pops it. The divider retires 8 dividend
// bits a cycle, one division by the target base per digit; digits are then read from
// the buffer MSB first into the output register. Reset clears accumulator, queue and
// sequencer state and sets the bases to 10 and 16; the digit buffer needs no clearing.
module radix_converter import rc_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        digit_code,
	output logic              last_digit,
	output logic              bad_char
);

	logic [BASE_W-1:0]  src_base_q;
	logic [BASE_W-1:0]  tgt_base_q;
	logic [BASE_W-1:0]  src_eff;
	logic [BASE_W-1:0]  tgt_eff;
	reg_idx_t           reg_idx;
	logic               wr_en;
	logic               push;
	logic [ACC_WIDTH:0] push_data;
	logic               pop;
	logic [ACC_WIDTH:0] pop_data;
	logic               q_full;
	logic               q_empty;

	// Register file access
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= SRC_BASE_RST;
			tgt_base_q <= TGT_BASE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SRC_BASE: src_base_q <= pwdata[BASE_W-1:0];
				REG_TGT_BASE: tgt_base_q <= pwdata[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SRC_BASE: prdata = APB_DW'(src_base_q);
			REG_TGT_BASE: prdata = APB_DW'(tgt_base_q);
			default:      prdata = '0;
		endcase
	end

	assign src_eff = clamp_base(src_base_q);
	assign tgt_eff = clamp_base(tgt_base_q);

	rc_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.src_base  (src_eff),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	rc_queue #(.DATA_W(ACC_WIDTH + 1)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	rc_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tgt_base   (tgt_eff),
		.q_empty    (q_empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_code (digit_code),
		.last_digit (last_digit),
		.bad_char   (bad_char)
	);

endmodule

// ===== rtl/rc_checker.sv =====
// Port-level checks on the radix converter, bound to the top level.
module rc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] digit_code,
	input logic       last_digit,
	input logic       bad_char
);

	// A stalled output beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// Error beat is a single terminal beat with a zero code
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_char |-> last_digit && digit_code == 8'h00)
		else $error("malformed error beat");

	// Digit beats carry uppercase hex ASCII
	a_digit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_char |->
			(digit_code >= 8'h30 && digit_code <= 8'h39) ||
			(digit_code >= 8'h41 && digit_code <= 8'h46))
		else $error("digit code outside 0-9 / A-F");

	// Config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind radix_converter rc_checker u_rc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digit_code (digit_code),
	.last_digit (last_digit),
	.bad_char   (bad_char)
);

// ===== dv/rc_digit_checker.sv =====
// Checker for the radix converter: predicts digit beats, compares them and counts failures.
`timescale 1ns / 1ps
module rc_digit_checker import rc_pkg::*; #(
	parameter int ACC_W = ACC_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        char_code,
	input  logic              last_char,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        digit_code,
	input  logic              last_digit,
	input  logic              bad_char,
	input  logic              run_done,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       bad;
	} digit_beat_t;

	// Shadow copies of the base registers and the number being built
	logic [BASE_W-1:0] src_base;
	logic [BASE_W-1:0] tgt_base;
	logic [ACC_W-1:0]  acc;
	logic              err_seen;
	logic              leftover_reported;
	digit_beat_t       expected_digits[$];
	digit_beat_t       want;

	// Register values outside 2..16 saturate
	function automatic logic [BASE_W-1:0] radix_of(input logic [BASE_W-1:0] b);
		if (b < BASE_MIN)
			return BASE_MIN;
		if (b > BASE_MAX)
			return BASE_MAX;
		return b;
	endfunction

	// Fold one character into the value; on the final one queue its digit beats
	task automatic take_char(input logic [7:0] c, input logic fin);
		logic [4:0]       v;
		logic [ACC_W-1:0] x;
		logic [ACC_W-1:0] b;
		logic [3:0]       digits [BUF_DEPTH];
		int               n;
		int               i;
		digit_beat_t      beat;
		// bit 4 flags a character that is not a hex digit; letters have low nibble 1..6
		if (c >= CH_0 && c <= CH_9)
			v = {1'b0, c[3:0]};
		else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF))
			v = {1'b0, c[3:0] + 4'd9};
		else
			v = 5'h10;
		if (v[4])
			err_seen = 1'b1;
		else
			acc = acc * ACC_W'(radix_of(src_base)) + ACC_W'(v[3:0]);
		if (!fin)
			return;
		if (err_seen) begin
			beat.code = CH_ERR;
			beat.last = 1'b1;
			beat.bad  = 1'b1;
			expected_digits.push_back(beat);
		end else begin
			// least significant digit first into the buffer, emitted in reverse
			b = ACC_W'(radix_of(tgt_base));
			x = acc;
			n = 0;
			do begin
				digits[n] = 4'(x % b);
				n++;
				x = x / b;
			end while (x != 0 && n < BUF_DEPTH);
			for (i = n - 1; i >= 0; i--) begin
				if (digits[i] < TEN)
					beat.code = CH_0 + 8'(digits[i]);
				else
					beat.code = CH_UA + 8'(digits[i]) - 8'(TEN);
				beat.last = (i == 0);
				beat.bad  = 1'b0;
				expected_digits.push_back(beat);
			end
		end
		acc      = '0;
		err_seen = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base          = SRC_BASE_RST;
			tgt_base          = TGT_BASE_RST;
			acc               = '0;
			err_seen          = 1'b0;
			leftover_reported = 1'b0;
			fail_count        = 0;
			expected_digits.delete();
			pending <= 0;
		end else begin
			// register writes on the access cycle
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_SRC_BASE: src_base = pwdata[BASE_W-1:0];
					REG_TGT_BASE: tgt_base = pwdata[BASE_W-1:0];
				endcase
			end

			if (in_valid && in_ready)
				take_char(char_code, last_char);

			// compare each result beat with the oldest expectation
			if (out_valid && out_ready) begin
				if (expected_digits.size() == 0) begin
					$error("unexpected result beat: digit_code %h last_digit %b bad_char %b",
						digit_code, last_digit, bad_char);
					fail_count++;
				end else begin
					want = expected_digits.pop_front();
					if (digit_code !== want.code) begin
						$error("digit_code: expected %h, got %h", want.code, digit_code);
						fail_count++;
					end
					if (last_digit !== want.last) begin
						$error("last_digit: expected %b, got %b", want.last, last_digit);
						fail_count++;
					end
					if (bad_char !== want.bad) begin
						$error("bad_char: expected %b, got %b", want.bad, bad_char);
						fail_count++;
					end
				end
			end

			if (run_done && !leftover_reported) begin
				leftover_reported = 1'b1;
				if (expected_digits.size() != 0) begin
					$error("%0d expected digit beats never arrived", expected_digits.size());
					fail_count++;
				end
			end

			pending <= expected_digits.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the radix converter testbench: clock, reset, base settings, character stimulus.
`timescale 1ns / 1ps
module testbench;
	import rc_pkg::*;

	localparam int ACC_W         = ACC_WIDTH_DEF;
	// worst case: full buffer of digits through the divider, then read out one by one
	localparam int SETTLE_CYCLES = ((ACC_W + 7) / 8) * (BUF_DEPTH + 2) + 2 * BUF_DEPTH + 32;
	localparam int TOTAL_ITEMS   = 260;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PLAN_LEN      = 6;

	typedef enum {
		NUM_CLEAN,
		NUM_WIDE,
		NUM_BROKEN,
		NUM_NOISE
	} num_style_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [2:0]        paddr        = '0;
	logic [APB_DW-1:0] pwdata       = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [7:0]        char_code    = '0;
	logic              last_char    = 1'b0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [7:0]        digit_code;
	logic              last_digit;
	logic              bad_char;
	logic              run_done     = 1'b0;
	logic              hold_off_req = 1'b0;
	int                fail_count;
	int                pending;

	// Stimulus bookkeeping
	logic [BASE_W-1:0] src_now     = SRC_BASE_RST;
	logic              valid_up    = 1'b0;
	int                items_sent  = 0;
	int                burst_left  = 0;
	int                cycle_count = 0;

	// Early phases hit the extremes and the saturating values
	logic [BASE_W-1:0] src_plan [PLAN_LEN] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd10};
	logic [BASE_W-1:0] tgt_plan [PLAN_LEN] = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd17, 5'd10};

	radix_converter #(
		.ACC_WIDTH(ACC_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_code (digit_code),
		.last_digit (last_digit),
		.bad_char   (bad_char)
	);

	rc_digit_checker #(
		.ACC_W(ACC_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_code (digit_code),
		.last_digit (last_digit),
		.bad_char   (bad_char),
		.run_done   (run_done),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial forever #4 clk = ~clk;

	// Setup-then-access register write; upper data bits are random and must be dropped
	task automatic write_reg(input reg_idx_t idx, input logic [BASE_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {27'($urandom()), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drop_valid();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	// Hold the input until every expected beat is out and the block has gone quiet
	task automatic settle();
		drop_valid();
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
		settle();
		write_reg(REG_SRC_BASE, src);
		write_reg(REG_TGT_BASE, tgt);
		src_now = src;
	endtask

	// One character beat, then maybe a gap at the end of a burst
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		in_valid  <= 1'b1;
		valid_up  = 1'b1;
		char_code <= c;
		last_char <= fin;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				drop_valid();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [7:0] digit_char(input int v);
		if (v < int'(TEN))
			return CH_0 + 8'(v);
		return (($urandom_range(0, 1) == 0) ? CH_UA : CH_LA) + 8'(v - int'(TEN));
	endfunction

	// A whole number, always closed by a last character
	task automatic send_number(input int len, input num_style_t style);
		int         eb;
		int         bad_pos;
		int         i;
		logic [7:0] c;
		eb = int'(src_now);
		if (eb < int'(BASE_MIN))
			eb = int'(BASE_MIN);
		else if (eb > int'(BASE_MAX))
			eb = int'(BASE_MAX);
		bad_pos = $urandom_range(0, len - 1);
		for (i = 0; i < len; i++) begin
			case (style)
				NUM_NOISE: c = 8'($urandom_range(0, 255));
				NUM_WIDE:  c = digit_char($urandom_range(0, 15));
				default:   c = digit_char($urandom_range(0, eb - 1));
			endcase
			if (style == NUM_BROKEN && i == bad_pos) begin
				do c = 8'($urandom_range(0, 255));
				while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
					(c >= CH_LA && c <= CH_LF));
			end
			send_char(c, i == len - 1);
		end
	endtask

	// Receiver: random stall patterns, plus one long hold-off on request
	initial begin
		int   mode;
		int   span;
		int   held;
		logic hold_done;
		mode      = 0;
		span      = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				for (held = 0; held < LONG_HOLD; held++)
					@(posedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 2);
					span = $urandom_range(10, 80);
				end
				span--;
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("run stopped at the cycle limit");
		$display("testbench NOT OK");
		$finish;
	end

	// Main stimulus
	initial begin
		int         phase;
		int         phase_end;
		int         len;
		int         pick;
		num_style_t style;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bases, decimal in and hex out: zero value gives a single '0'
		send_char(CH_0, 1'b1);
		// letters of both cases, above the source base, are still folded in
		send_char(CH_LA, 1'b0);
		send_char(CH_UF, 1'b0);
		send_char(CH_9, 1'b1);
		send_char(CH_LF, 1'b0);
		send_char(CH_UA, 1'b1);
		// bad character early, then a good last one: one error beat
		send_char(8'h00, 1'b0);
		send_char(CH_0 + 8'd5, 1'b1);
		// bad character as the last one
		send_char(8'hFF, 1'b1);
		// the neighbors of every hex range are rejected
		send_char(CH_0 - 8'd1, 1'b0);
		send_char(CH_9 + 8'd1, 1'b0);
		send_char(CH_UA - 8'd1, 1'b0);
		send_char(CH_UF + 8'd1, 1'b0);
		send_char(CH_LA - 8'd1, 1'b0);
		send_char(CH_LF + 8'd1, 1'b1);

		// hex in, binary out: 1FFFFFFFF wraps to all ones, the full 32-digit result
		set_bases(5'd16, 5'd2);
		send_char(CH_0 + 8'd1, 1'b0);
		repeat (7) send_char(CH_UF, 1'b0);
		send_char(CH_UF, 1'b1);

		// random phases, each under its own base setting
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			if (phase < PLAN_LEN)
				set_bases(src_plan[phase], tgt_plan[phase]);
			else if ($urandom_range(0, 4) == 0)
				set_bases(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			else
				set_bases(5'($urandom_range(2, 16)), 5'($urandom_range(2, 16)));
			// one phase runs into a long receiver hold-off so the input backs up
			if (phase == 2)
				hold_off_req <= 1'b1;
			phase_end = items_sent + $urandom_range(20, 40);
			while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = $urandom_range(12, 20);
				else if (pick < 55)
					len = $urandom_range(1, 4);
				else
					len = $urandom_range(1, 12);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					style = NUM_CLEAN;
				else if (pick < 82)
					style = NUM_WIDE;
				else if (pick < 92)
					style = NUM_BROKEN;
				else
					style = NUM_NOISE;
				send_number(len, style);
			end
			phase++;
		end

		settle();
		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rc_pkg.sv
rtl/rc_queue.sv
rtl/rc_front.sv
rtl/rc_back.sv
rtl/radix_converter.sv
rtl/rc_checker.sv
dv/rc_digit_checker.sv
dv/testbench.sv
